// ===== rtl/rgbe_pkg.sv =====
package rgbe_pkg;

  localparam int MAX_WIDTH = 4096;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int LEN_W     = 16;
  localparam int CODE_W    = 7;
  localparam int IDX_W     = 12;
  localparam int PIX_W     = 32;

  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [LEN_W:0]    len_ext_t;
  typedef logic [COL_W-1:0]  col_t;
  typedef logic [CODE_W-1:0] code_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [PIX_W-1:0]  pix_t;

  // position within one scanline record
  typedef enum logic [7:0] {
    PH_MARK0  = 8'b0000_0001,
    PH_MARK1  = 8'b0000_0010,
    PH_LEN_HI = 8'b0000_0100,
    PH_LEN_LO = 8'b0000_1000,
    PH_R      = 8'b0001_0000,
    PH_G      = 8'b0010_0000,
    PH_B      = 8'b0100_0000,
    PH_E      = 8'b1000_0000
  } phase_e;

  typedef struct packed {
    logic   ld_len_hi;
    logic   ld_len_lo;
    logic   clr_fill;
    logic   lit_step;
    logic   run_load;
    logic   run_step;
    code_t  run_count;
    phase_e chan;
  } dp_cmd_t;

  typedef struct packed {
    logic fill_ge_len;
    logic fill_last;
    logic len_zero_next;
    logic rem_zero;
    logic p_free;
  } dp_status_t;

endpackage

// ===== rtl/rgbe_byte_if.sv =====
interface rgbe_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink (input valid, input stream_byte, output ready);
endinterface

// ===== rtl/rgbe_beat_if.sv =====
interface rgbe_beat_if;
  logic                  valid;
  logic                  ready;
  rgbe_pkg::pix_t        first_pixel;
  rgbe_pkg::pix_t        second_pixel;
  logic [1:0]            pair_count;
  rgbe_pkg::idx_t        pixel_index;
  logic                  end_of_line;
  logic                  last;
  logic                  width_error;

  modport source (
    output valid, output first_pixel, output second_pixel, output pair_count,
    output pixel_index, output end_of_line, output last, output width_error,
    input ready
  );
  modport sink (
    input valid, input first_pixel, input second_pixel, input pair_count,
    input pixel_index, input end_of_line, input last, input width_error,
    output ready
  );
endinterface

// ===== rtl/rgbe_ctrl.sv =====
module rgbe_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic [7:0]           in_byte_i,
  output logic                 in_ready_o,
  input  rgbe_pkg::dp_status_t status_i,
  output rgbe_pkg::dp_cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    ST_BYTE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  state_e               state_q, state_d;
  rgbe_pkg::phase_e     phase_q, phase_d;
  rgbe_pkg::code_t      pend_q, pend_d;
  logic                 runexp_q, runexp_d;
  logic                 lit_wait;
  logic                 fire;

  function automatic rgbe_pkg::phase_e next_chan(rgbe_pkg::phase_e ph);
    rgbe_pkg::phase_e nx;
    unique case (ph)
      rgbe_pkg::PH_R: nx = rgbe_pkg::PH_G;
      rgbe_pkg::PH_G: nx = rgbe_pkg::PH_B;
      rgbe_pkg::PH_B: nx = rgbe_pkg::PH_E;
      default:        nx = rgbe_pkg::PH_MARK0;
    endcase
    return nx;
  endfunction

  // an e literal needs room in the pixel pipe before it is taken
  assign lit_wait = (phase_q == rgbe_pkg::PH_E) && !runexp_q && (pend_q != '0) &&
                    !status_i.p_free;

  always_comb begin
    state_d   = state_q;
    phase_d   = phase_q;
    pend_d    = pend_q;
    runexp_d  = runexp_q;
    cmd_o     = '0;
    cmd_o.chan      = phase_q;
    cmd_o.run_count = pend_q;
    in_ready_o = 1'b0;
    fire       = 1'b0;
    unique case (state_q)
      ST_BYTE: begin
        in_ready_o = !lit_wait;
        fire       = in_valid_i && !lit_wait;
        if (fire) begin
          unique case (phase_q)
            rgbe_pkg::PH_MARK0: phase_d = rgbe_pkg::PH_MARK1;
            rgbe_pkg::PH_MARK1: phase_d = rgbe_pkg::PH_LEN_HI;
            rgbe_pkg::PH_LEN_HI: begin
              cmd_o.ld_len_hi = 1'b1;
              phase_d         = rgbe_pkg::PH_LEN_LO;
            end
            rgbe_pkg::PH_LEN_LO: begin
              cmd_o.ld_len_lo = 1'b1;
              cmd_o.clr_fill  = 1'b1;
              pend_d          = '0;
              runexp_d        = 1'b0;
              phase_d = status_i.len_zero_next ? rgbe_pkg::PH_MARK0 : rgbe_pkg::PH_R;
            end
            rgbe_pkg::PH_R, rgbe_pkg::PH_G, rgbe_pkg::PH_B, rgbe_pkg::PH_E: begin
              if (runexp_q) begin
                cmd_o.run_load = 1'b1;
                runexp_d       = 1'b0;
                pend_d         = '0;
                state_d        = ST_RUN;
              end else if (pend_q != '0) begin
                cmd_o.lit_step = 1'b1;
                pend_d         = pend_q - rgbe_pkg::code_t'(1);
                if ((pend_q == rgbe_pkg::code_t'(1)) && status_i.fill_last) begin
                  cmd_o.clr_fill = 1'b1;
                  phase_d        = next_chan(phase_q);
                end
              end else if (!in_byte_i[7]) begin
                pend_d = in_byte_i[6:0];
                // empty literal packet closes at once
                if ((in_byte_i[6:0] == '0) && status_i.fill_ge_len) begin
                  cmd_o.clr_fill = 1'b1;
                  phase_d        = next_chan(phase_q);
                end
              end else begin
                pend_d   = in_byte_i[6:0];
                runexp_d = 1'b1;
              end
            end
            default: phase_d = rgbe_pkg::PH_MARK0;
          endcase
        end
      end
      ST_RUN: begin
        if (status_i.rem_zero) begin
          state_d = ST_BYTE;
          if (status_i.fill_ge_len) begin
            cmd_o.clr_fill = 1'b1;
            phase_d        = next_chan(phase_q);
          end
        end else if ((phase_q != rgbe_pkg::PH_E) || status_i.p_free) begin
          cmd_o.run_step = 1'b1;
        end
      end
      default: state_d = ST_BYTE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_BYTE;
      phase_q  <= rgbe_pkg::PH_MARK0;
      pend_q   <= '0;
      runexp_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      phase_q  <= phase_d;
      pend_q   <= pend_d;
      runexp_q <= runexp_d;
    end
  end

endmodule

// ===== rtl/rgbe_dp.sv =====
module rgbe_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [7:0]           in_byte_i,
  input  rgbe_pkg::dp_cmd_t    cmd_i,
  output rgbe_pkg::dp_status_t status_o,
  rgbe_beat_if.source          beat_o
);

  rgbe_pkg::len_t     len_q, len_d;
  rgbe_pkg::len_t     fill_q, fill_d;
  rgbe_pkg::code_t    rem_q, rem_d;
  logic [7:0]         run_val_q;

  rgbe_pkg::len_ext_t fill_ext, len_ext, max_ext, span, fill_inc;
  rgbe_pkg::len_t     diff;
  rgbe_pkg::code_t    eff;
  rgbe_pkg::col_t     col;
  logic               fill_ge_len, in_range;
  logic               do_op, we_r, we_g, we_b, issue;
  logic [7:0]         val;

  logic [7:0] red_mem   [rgbe_pkg::MAX_WIDTH];
  logic [7:0] green_mem [rgbe_pkg::MAX_WIDTH];
  logic [7:0] blue_mem  [rgbe_pkg::MAX_WIDTH];
  logic [7:0] red_rd_q, green_rd_q, blue_rd_q;

  // pixel stage: value waiting for its line store read
  logic           p_valid_q;
  logic [7:0]     p_val_q;
  rgbe_pkg::col_t p_col_q;
  logic           p_eol_q, p_werr_q, p_last_q;
  rgbe_pkg::pix_t p_pix;
  // holding slot for the first pixel of a pair
  logic           h_valid_q;
  rgbe_pkg::pix_t h_pix_q;
  rgbe_pkg::col_t h_col_q;
  // output register
  logic           o_valid_q;
  rgbe_pkg::pix_t o_first_q, o_second_q;
  logic [1:0]     o_count_q;
  rgbe_pkg::idx_t o_idx_q;
  logic           o_eol_q, o_last_q, o_werr_q;

  logic o_free, p_take, p_to_h, p_to_o;

  assign fill_ext    = {1'b0, fill_q};
  assign len_ext     = {1'b0, len_q};
  assign max_ext     = rgbe_pkg::len_ext_t'(rgbe_pkg::MAX_WIDTH);
  assign fill_inc    = fill_ext + rgbe_pkg::len_ext_t'(1);
  assign span        = (len_ext < max_ext) ? len_ext : max_ext;
  assign fill_ge_len = (fill_q >= len_q);
  assign in_range    = (fill_ext < max_ext);
  assign col         = fill_q[rgbe_pkg::COL_W-1:0];
  assign diff        = len_q - fill_q;
  assign eff = fill_ge_len ? '0 :
               (diff < rgbe_pkg::len_t'(cmd_i.run_count)) ? rgbe_pkg::code_t'(diff) :
               cmd_i.run_count;

  assign val   = cmd_i.run_step ? run_val_q : in_byte_i;
  assign do_op = (cmd_i.lit_step && !fill_ge_len && in_range) ||
                 (cmd_i.run_step && in_range);
  assign we_r  = do_op && (cmd_i.chan == rgbe_pkg::PH_R);
  assign we_g  = do_op && (cmd_i.chan == rgbe_pkg::PH_G);
  assign we_b  = do_op && (cmd_i.chan == rgbe_pkg::PH_B);
  assign issue = do_op && (cmd_i.chan == rgbe_pkg::PH_E);

  assign status_o.fill_ge_len   = fill_ge_len;
  assign status_o.fill_last     = (fill_inc >= len_ext);
  assign status_o.len_zero_next = ({len_q[15:8], in_byte_i} == '0);
  assign status_o.rem_zero      = (rem_q == '0);
  assign status_o.p_free        = !p_valid_q || p_take;

  always_comb begin
    len_d  = len_q;
    fill_d = fill_q;
    rem_d  = rem_q;
    if (cmd_i.ld_len_hi) len_d = {in_byte_i, 8'h00};
    if (cmd_i.ld_len_lo) len_d = {len_q[15:8], in_byte_i};
    if (cmd_i.clr_fill) begin
      fill_d = '0;
    end else if (cmd_i.lit_step && !fill_ge_len) begin
      fill_d = fill_q + rgbe_pkg::len_t'(1);
    end else if (cmd_i.run_step) begin
      // past the store width the rest of the run only advances the count
      fill_d = in_range ? fill_q + rgbe_pkg::len_t'(1) : fill_q + rgbe_pkg::len_t'(rem_q);
    end
    if (cmd_i.run_load) begin
      rem_d = eff;
    end else if (cmd_i.run_step) begin
      rem_d = in_range ? rem_q - rgbe_pkg::code_t'(1) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      fill_q <= '0;
      rem_q  <= '0;
    end else begin
      len_q  <= len_d;
      fill_q <= fill_d;
      rem_q  <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.run_load) run_val_q <= in_byte_i;
  end

  always_ff @(posedge clk_i) begin
    if (we_r) red_mem[col] <= val;
    if (issue) red_rd_q <= red_mem[col];
  end

  always_ff @(posedge clk_i) begin
    if (we_g) green_mem[col] <= val;
    if (issue) green_rd_q <= green_mem[col];
  end

  always_ff @(posedge clk_i) begin
    if (we_b) blue_mem[col] <= val;
    if (issue) blue_rd_q <= blue_mem[col];
  end

  assign p_pix  = {red_rd_q, green_rd_q, blue_rd_q, p_val_q};
  assign o_free = !o_valid_q || beat_o.ready;
  assign p_to_h = p_valid_q && !h_valid_q && !p_last_q;
  assign p_to_o = p_valid_q && !p_to_h && o_free;
  assign p_take = p_to_h || p_to_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      h_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (issue) p_valid_q <= 1'b1;
      else if (p_take) p_valid_q <= 1'b0;
      if (p_to_h) h_valid_q <= 1'b1;
      else if (p_to_o) h_valid_q <= 1'b0;
      if (p_to_o) o_valid_q <= 1'b1;
      else if (beat_o.ready) o_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      p_val_q  <= val;
      p_col_q  <= col;
      p_eol_q  <= (fill_inc == span);
      p_werr_q <= (len_ext > max_ext);
      p_last_q <= cmd_i.lit_step || (rem_q == rgbe_pkg::code_t'(1)) || (fill_inc >= max_ext);
    end
    if (p_to_h) begin
      h_pix_q <= p_pix;
      h_col_q <= p_col_q;
    end
    if (p_to_o) begin
      if (h_valid_q) begin
        o_first_q  <= h_pix_q;
        o_second_q <= p_pix;
        o_count_q  <= 2'd2;
        o_idx_q    <= rgbe_pkg::idx_t'(h_col_q);
      end else begin
        o_first_q  <= p_pix;
        o_second_q <= '0;
        o_count_q  <= 2'd1;
        o_idx_q    <= rgbe_pkg::idx_t'(p_col_q);
      end
      o_eol_q  <= p_eol_q;
      o_last_q <= p_last_q;
      o_werr_q <= p_werr_q;
    end
  end

  assign beat_o.valid        = o_valid_q;
  assign beat_o.first_pixel  = o_first_q;
  assign beat_o.second_pixel = o_second_q;
  assign beat_o.pair_count   = o_count_q;
  assign beat_o.pixel_index  = o_idx_q;
  assign beat_o.end_of_line  = o_eol_q;
  assign beat_o.last         = o_last_q;
  assign beat_o.width_error  = o_werr_q;

endmodule

// ===== rtl/rgbe_scanline_rle_decoder_unit.sv =====
// pipeline: an e literal passes the pixel stage into the output register once that has room;
// a run value is registered; its e values pass the pixel stage and pair in the holding slot
// throughput: one byte per cycle for markers, length, codes and literals while the pixel pipe
// has room; a run value holds the input until every value of its run is stored or emitted,
// as each line store has a single write and read port; past the store width a run ends
// reset: rst_ni clears the parser and the pixel pipe; line stores keep their contents
module rgbe_scanline_rle_decoder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  rgbe_byte_if.sink   byte_i,
  rgbe_beat_if.source beat_o
);

  rgbe_pkg::dp_cmd_t    cmd;
  rgbe_pkg::dp_status_t status;
  logic                 in_ready;

  assign byte_i.ready = in_ready;

  rgbe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (byte_i.valid),
    .in_byte_i  (byte_i.stream_byte),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rgbe_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_byte_i (byte_i.stream_byte),
    .cmd_i     (cmd),
    .status_o  (status),
    .beat_o    (beat_o)
  );

endmodule
